// File: rtl/lkc_pkg.sv
`default_nettype none
package lkc_pkg;

    localparam int ENTRIES    = 16;
    localparam int COUNT_BITS = 16;
    localparam int KEY_W      = 8;
    localparam int CAP_W      = 5;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W      = $clog2(ENTRIES + 1);
    localparam int CMP_W      = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam int ENTRY_W    = KEY_W + COUNT_BITS;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [CAP_W-1:0]  CAP_RESET     = CAP_W'(16);
    localparam logic [ADDR_W-1:0] ADDR_CAPACITY = ADDR_W'(0);

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic             start;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// File: rtl/lfu_key_cache.sv
`default_nettype none
// Least-frequently-used cache of byte keys. Each input transaction looks a key up
// (kind 0) or inserts it (kind 1); a hit bumps the entry's saturating use count, and
// an insert miss adds the key with count 1, first evicting the entry with the lowest
// count (ties to the lowest key) once occupancy reaches the capacity register. Every
// input transaction yields exactly one result transaction with hit, evicted and the
// evicted key. The keys and counts live in a single-port-write, registered-read RAM
// that is scanned one entry per cycle, so a new item is accepted only after the
// previous one has been scanned and its result committed, later still while a finished
// result is held by the output stall. The capacity register sits at byte address 0;
// zero acts as 1 and values above the entry count act as the entry count.
module lfu_key_cache (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,

    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic                         i_kind,
    input  wire logic [lkc_pkg::KEY_W-1:0]    i_key,

    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic                              o_hit,
    output logic                              o_evicted,
    output logic      [lkc_pkg::KEY_W-1:0]    o_evicted_key,

    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [lkc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [lkc_pkg::DATA_W-1:0]   pwdata,
    output logic      [lkc_pkg::DATA_W-1:0]   prdata,
    output logic                              pready
);
    import lkc_pkg::*;

    logic [CAP_W-1:0] r_capacity;
    t_cmd             w_cmd;
    t_sts             w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY)) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CAPACITY) ? DATA_W'(r_capacity) : '0;

    lkc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    lkc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_capacity   (r_capacity),
        .i_kind       (i_kind),
        .i_key        (i_key),
        .o_out_valid  (o_out_valid),
        .o_hit        (o_hit),
        .o_evicted    (o_evicted),
        .o_evicted_key(o_evicted_key),
        .i_out_stall  (i_out_stall)
    );

endmodule
`default_nettype wire

// File: rtl/lkc_ram.sv
`default_nettype none
module lkc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                           i_wr_data,
    input  wire logic                                       i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/lkc_ctrl.sv
`default_nettype none
module lkc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire lkc_pkg::t_sts i_sts,
    output lkc_pkg::t_cmd      o_cmd
);
    import lkc_pkg::*;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic             w_last;

    assign w_last = (r_cnt == IDX_W'(ENTRIES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_cnt = r_cnt + IDX_W'(1);
                if (w_last) begin
                    n_state = ST_DRAIN;
                end
            end
            // last read data is compared in this cycle
            ST_DRAIN: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall    = 1'b1;
        o_cmd.start   = 1'b0;
        o_cmd.rd_en   = 1'b0;
        o_cmd.rd_addr = r_cnt;
        o_cmd.commit  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.start = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
            end
            ST_DRAIN: begin
                o_cmd.rd_en = 1'b0;
            end
            ST_COMMIT: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/lkc_dp.sv
`default_nettype none
module lkc_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire lkc_pkg::t_cmd               i_cmd,
    output lkc_pkg::t_sts                    o_sts,
    input  wire logic [lkc_pkg::CAP_W-1:0]   i_capacity,
    input  wire logic                        i_kind,
    input  wire logic [lkc_pkg::KEY_W-1:0]   i_key,
    output logic                             o_out_valid,
    output logic                             o_hit,
    output logic                             o_evicted,
    output logic      [lkc_pkg::KEY_W-1:0]   o_evicted_key,
    input  wire logic                        i_out_stall
);
    import lkc_pkg::*;

    logic                  r_kind;
    logic [KEY_W-1:0]      r_key;
    logic [ENTRIES-1:0]    r_valid, n_valid;
    logic [OCC_W-1:0]      r_occ;
    logic                  r_rd_vld;
    logic [IDX_W-1:0]      r_rd_idx;

    logic                  r_match_found;
    logic [IDX_W-1:0]      r_match_idx;
    logic [COUNT_BITS-1:0] r_match_cnt;
    logic                  r_vic_found;
    logic [IDX_W-1:0]      r_vic_idx;
    logic [KEY_W-1:0]      r_vic_key;
    logic [COUNT_BITS-1:0] r_vic_cnt;
    logic                  r_free_found;
    logic [IDX_W-1:0]      r_free_idx;

    logic                  r_out_valid;
    logic                  r_hit;
    logic                  r_evicted;
    logic [KEY_W-1:0]      r_evicted_key;

    logic [ENTRY_W-1:0]    w_rd_data;
    logic [KEY_W-1:0]      w_rd_key;
    logic [COUNT_BITS-1:0] w_rd_cnt;
    logic                  w_live, w_match_now, w_better, w_free_now;

    logic [CMP_W-1:0]      w_cap_x, w_eff_cap;
    logic                  w_miss_ins, w_do_evict, w_do_ins, w_ins_vic;
    logic [IDX_W-1:0]      w_ins_idx;
    logic [COUNT_BITS-1:0] w_inc_cnt;
    logic                  w_wr_en;
    logic [IDX_W-1:0]      w_wr_addr;
    logic [ENTRY_W-1:0]    w_wr_data;

    lkc_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(ENTRIES)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_en  (i_cmd.rd_en),
        .i_rd_addr(i_cmd.rd_addr),
        .o_rd_data(w_rd_data)
    );

    // scan side: one entry compared per cycle
    assign w_rd_key    = w_rd_data[ENTRY_W-1 -: KEY_W];
    assign w_rd_cnt    = w_rd_data[COUNT_BITS-1:0];
    assign w_live      = r_rd_vld && r_valid[r_rd_idx];
    assign w_match_now = w_live && (w_rd_key == r_key) && !r_match_found;
    assign w_better    = w_live && (!r_vic_found || (w_rd_cnt < r_vic_cnt) ||
                         ((w_rd_cnt == r_vic_cnt) && (w_rd_key < r_vic_key)));
    assign w_free_now  = r_rd_vld && !r_valid[r_rd_idx] && !r_free_found;

    // commit side
    always_comb begin
        w_cap_x = CMP_W'(i_capacity);
        if (w_cap_x == '0) begin
            w_eff_cap = CMP_W'(1);
        end else if (w_cap_x > CMP_W'(ENTRIES)) begin
            w_eff_cap = CMP_W'(ENTRIES);
        end else begin
            w_eff_cap = w_cap_x;
        end
    end

    assign w_miss_ins = !r_match_found && (r_kind == KIND_INSERT);
    assign w_do_evict = w_miss_ins && (CMP_W'(r_occ) >= w_eff_cap) && r_vic_found;
    assign w_ins_vic  = w_do_evict && (!r_free_found || (r_vic_idx < r_free_idx));
    assign w_ins_idx  = w_ins_vic ? r_vic_idx : r_free_idx;
    assign w_do_ins   = w_miss_ins && (w_do_evict || r_free_found);
    assign w_inc_cnt  = (r_match_cnt == '1) ? r_match_cnt : r_match_cnt + COUNT_BITS'(1);

    assign w_wr_en    = i_cmd.commit && (r_match_found || w_do_ins);
    assign w_wr_addr  = r_match_found ? r_match_idx : w_ins_idx;
    assign w_wr_data  = r_match_found ? {r_key, w_inc_cnt} : {r_key, COUNT_BITS'(1)};

    always_comb begin
        n_valid = r_valid;
        if (w_do_evict) begin
            n_valid[r_vic_idx] = 1'b0;
        end
        if (w_do_ins) begin
            n_valid[w_ins_idx] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_occ       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.commit) begin
                r_valid     <= n_valid;
                r_occ       <= r_occ - OCC_W'(w_do_evict) + OCC_W'(w_do_ins);
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= i_cmd.rd_addr;
        if (i_cmd.start) begin
            r_kind        <= i_kind;
            r_key         <= i_key;
            r_match_found <= 1'b0;
            r_vic_found   <= 1'b0;
            r_free_found  <= 1'b0;
        end else begin
            if (w_match_now) begin
                r_match_found <= 1'b1;
                r_match_idx   <= r_rd_idx;
                r_match_cnt   <= w_rd_cnt;
            end
            if (w_better) begin
                r_vic_found <= 1'b1;
                r_vic_idx   <= r_rd_idx;
                r_vic_key   <= w_rd_key;
                r_vic_cnt   <= w_rd_cnt;
            end
            if (w_free_now) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_rd_idx;
            end
        end
        if (i_cmd.commit) begin
            r_hit         <= r_match_found;
            r_evicted     <= w_do_evict;
            r_evicted_key <= w_do_evict ? r_vic_key : '0;
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_hit;
    assign o_evicted      = r_evicted;
    assign o_evicted_key  = r_evicted_key;

endmodule
`default_nettype wire
